[hdl/mbe_pkg.sv]
`default_nettype none
package mbe_pkg;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned SUM_W     = 43;
  localparam int unsigned PROD_W    = 2 * Q_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON  = 3'd5;

  localparam logic signed [Q_W-1:0] X_MIN_RST    = 32'shE000_0000;
  localparam logic signed [Q_W-1:0] Y_MIN_RST    = 32'shEC00_0000;
  localparam logic [STEP_W-1:0]     X_STEP_RST   = 31'h000A_0000;
  localparam logic [STEP_W-1:0]     Y_STEP_RST   = 31'h000A_0000;
  localparam logic [ITER_W-1:0]     MAX_ITER_RST = 16'd256;
  localparam logic [STEP_W-1:0]     HORIZON_RST  = 31'h4000_0000;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic eval;
  } mbe_cmd_t;

  typedef struct packed {
    logic              escaped;
    logic [ITER_W-1:0] max_iter;
  } mbe_status_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] res;
    if (v[SUM_W-1:Q_W-1] == {(SUM_W-Q_W+1){1'b0}} ||
        v[SUM_W-1:Q_W-1] == {(SUM_W-Q_W+1){1'b1}}) begin
      res = v[Q_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/mbe_datapath.sv]
`default_nettype none
module mbe_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbe_pkg::CFG_DW-1:0]    cfg_data,
  input  wire logic [mbe_pkg::IDX_W-1:0]     in_col,
  input  wire logic [mbe_pkg::IDX_W-1:0]     in_row,
  input  wire mbe_pkg::mbe_cmd_t             cmd,
  output mbe_pkg::mbe_status_t               status,
  output logic [mbe_pkg::IDX_W-1:0]          out_col,
  output logic [mbe_pkg::IDX_W-1:0]          out_row
);

  localparam int unsigned PX_W = mbe_pkg::IDX_W + mbe_pkg::STEP_W;
  localparam int unsigned QW   = mbe_pkg::Q_W;
  localparam int unsigned PW   = mbe_pkg::PROD_W;
  localparam int unsigned SW   = mbe_pkg::SUM_W;
  localparam int unsigned FB   = mbe_pkg::FRAC_BITS;

  logic signed [QW-1:0]               x_min_r, y_min_r;
  logic [mbe_pkg::STEP_W-1:0]         x_step_r, y_step_r, horizon_r;
  logic [mbe_pkg::ITER_W-1:0]         max_iter_r;

  logic [mbe_pkg::IDX_W-1:0]          col_r, row_r;
  logic [PX_W-1:0]                    px_r, py_r;
  logic signed [QW-1:0]               cr_r, ci_r, zr_r, zi_r;
  logic signed [PW-1:0]               srr_r, sii_r, sri_r;

  logic signed [SW-1:0]               cr_sum, ci_sum, re_sum, im_sum;
  logic signed [QW-1:0]               cr_nxt, ci_nxt;
  logic signed [PW-1:0]               srr_nxt, sii_nxt, sri_nxt, diff;
  logic [PW-1:0]                      mag, limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= mbe_pkg::X_MIN_RST;
      y_min_r    <= mbe_pkg::Y_MIN_RST;
      x_step_r   <= mbe_pkg::X_STEP_RST;
      y_step_r   <= mbe_pkg::Y_STEP_RST;
      max_iter_r <= mbe_pkg::MAX_ITER_RST;
      horizon_r  <= mbe_pkg::HORIZON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::REG_X_MIN:    x_min_r    <= cfg_data;
        mbe_pkg::REG_Y_MIN:    y_min_r    <= cfg_data;
        mbe_pkg::REG_X_STEP:   x_step_r   <= cfg_data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_Y_STEP:   y_step_r   <= cfg_data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITER: max_iter_r <= cfg_data[mbe_pkg::ITER_W-1:0];
        mbe_pkg::REG_HORIZON:  horizon_r  <= cfg_data[mbe_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cr_sum  = SW'(x_min_r) + $signed({{(SW-PX_W){1'b0}}, px_r});
    ci_sum  = SW'(y_min_r) + $signed({{(SW-PX_W){1'b0}}, py_r});
    cr_nxt  = mbe_pkg::sat_q(cr_sum);
    ci_nxt  = mbe_pkg::sat_q(ci_sum);
    srr_nxt = PW'(zr_r) * PW'(zr_r);
    sii_nxt = PW'(zi_r) * PW'(zi_r);
    sri_nxt = PW'(zr_r) * PW'(zi_r);
    diff    = srr_r - sii_r;
    re_sum  = SW'($signed(diff[PW-1:FB])) + SW'(cr_r);
    im_sum  = SW'($signed(sri_r[PW-1:FB-1])) + SW'(ci_r);
    mag     = srr_r + sii_r;
    limit   = {{(PW-mbe_pkg::STEP_W-FB){1'b0}}, horizon_r, {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_col;
      row_r <= in_row;
      px_r  <= PX_W'(in_col) * PX_W'(x_step_r);
      py_r  <= PX_W'(in_row) * PX_W'(y_step_r);
    end
    if (cmd.setup) begin
      cr_r <= cr_nxt;
      ci_r <= ci_nxt;
      zr_r <= cr_nxt;
      zi_r <= ci_nxt;
    end
    if (cmd.mul) begin
      srr_r <= srr_nxt;
      sii_r <= sii_nxt;
      sri_r <= sri_nxt;
    end
    if (cmd.eval) begin
      zr_r <= mbe_pkg::sat_q(re_sum);
      zi_r <= mbe_pkg::sat_q(im_sum);
    end
  end

  assign status.escaped  = mag > limit;
  assign status.max_iter = max_iter_r;
  assign out_col         = col_r;
  assign out_row         = row_r;

endmodule
`default_nettype wire

[hdl/mbe_ctrl.sv]
`default_nettype none
module mbe_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire mbe_pkg::mbe_status_t       status,
  output mbe_pkg::mbe_cmd_t               cmd,
  output logic                            busy,
  output logic                            out_valid,
  output logic [mbe_pkg::ITER_W-1:0]      out_escape_count
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_MUL, S_EVAL} state_t;

  state_t                     state_r;
  logic                       busy_r, out_valid_r;
  logic [mbe_pkg::ITER_W-1:0] n_r, count_r, n_inc;

  assign n_inc = n_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SETUP;
            busy_r  <= 1'b1;
          end
        end
        S_SETUP: begin
          n_r <= '0;
          if (status.max_iter == '0) begin
            state_r     <= S_IDLE;
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
            count_r     <= '0;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_EVAL;
        S_EVAL: begin
          if (status.escaped || n_inc == status.max_iter) begin
            state_r     <= S_IDLE;
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
            count_r     <= status.escaped ? n_r : '0;
          end else begin
            n_r     <= n_inc;
            state_r <= S_MUL;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.load          = (state_r == S_IDLE) && start;
  assign cmd.setup         = state_r == S_SETUP;
  assign cmd.mul           = state_r == S_MUL;
  assign cmd.eval          = state_r == S_EVAL;
  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_escape_count  = count_r;

endmodule
`default_nettype wire

[hdl/mandelbrot_escape_time.sv]
// Channel  Handshake                  Payload
// input    start, busy                in_col, in_row
// result   out_valid (one-cycle beat) out_col, out_row, out_escape_count
// config   cfg_we                     cfg_index, cfg_data
//
// A beat is taken when start is high and busy is low; busy stays high until the result.
// After its input beat, one item takes a setup step, then k escape tests, then its
// result beat, k being the number of escape tests made (at most the iteration limit);
// each test multiplies, then evaluates and updates, in the shared square-and-add unit.
// Reset is synchronous, active low, and restores the register defaults.
// The receiver cannot stall: a result beat lasts exactly one cycle.
`default_nettype none
module mandelbrot_escape_time (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mbe_pkg::IDX_W-1:0]     in_col,
  input  wire logic [mbe_pkg::IDX_W-1:0]     in_row,
  output logic                               out_valid,
  output logic [mbe_pkg::IDX_W-1:0]          out_col,
  output logic [mbe_pkg::IDX_W-1:0]          out_row,
  output logic [mbe_pkg::ITER_W-1:0]         out_escape_count,
  input  wire logic                          cfg_we,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbe_pkg::CFG_DW-1:0]    cfg_data
);

  mbe_pkg::mbe_cmd_t    cmd;
  mbe_pkg::mbe_status_t status;

  mbe_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .status           (status),
    .cmd              (cmd),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count)
  );

  mbe_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_col    (in_col),
    .in_row    (in_row),
    .cmd       (cmd),
    .status    (status),
    .out_col   (out_col),
    .out_row   (out_row)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.setup, cmd.mul, cmd.eval}))
    else $error("datapath commands overlap");

endmodule
`default_nettype wire

[tb/mandelbrot_escape_time_tb.sv]
`default_nettype none
module mandelbrot_escape_time_tb;

  localparam int unsigned POINT_TARGET = 1550;
  localparam int unsigned STALL_LIMIT  = 1000000;
  localparam longint      Q_HI         = 64'sd2147483647;
  localparam longint      Q_LO         = -64'sd2147483648;

  typedef struct {
    logic [mbe_pkg::IDX_W-1:0]  col;
    logic [mbe_pkg::IDX_W-1:0]  row;
    logic [mbe_pkg::ITER_W-1:0] count;
  } point_result_t;

  class escape_tracker;
    longint        x_min;
    longint        y_min;
    longint        x_step;
    longint        y_step;
    longint        iter_limit;
    longint        horizon;
    point_result_t due_points[$];
    int unsigned   mismatches;

    function new();
      x_min      = longint'(mbe_pkg::X_MIN_RST);
      y_min      = longint'(mbe_pkg::Y_MIN_RST);
      x_step     = longint'(mbe_pkg::X_STEP_RST);
      y_step     = longint'(mbe_pkg::Y_STEP_RST);
      iter_limit = longint'(mbe_pkg::MAX_ITER_RST);
      horizon    = longint'(mbe_pkg::HORIZON_RST);
      mismatches = 0;
    endfunction

    function void write_reg(logic [mbe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        mbe_pkg::REG_X_MIN:    x_min      = longint'($signed(data));
        mbe_pkg::REG_Y_MIN:    y_min      = longint'($signed(data));
        mbe_pkg::REG_X_STEP:   x_step     = longint'(data[30:0]);
        mbe_pkg::REG_Y_STEP:   y_step     = longint'(data[30:0]);
        mbe_pkg::REG_MAX_ITER: iter_limit = longint'(data[15:0]);
        mbe_pkg::REG_HORIZON:  horizon    = longint'(data[30:0]);
        default: ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
    endfunction

    function longint unsigned sq_mag(longint a);
      longint unsigned m;
      m = (a < 0) ? -a : a;
      return m * m;
    endfunction

    function logic [mbe_pkg::ITER_W-1:0] escape_count_of(longint cr, longint ci);
      longint          zr;
      longint          zi;
      longint          re;
      longint          im;
      longint unsigned lim;
      zr  = cr;
      zi  = ci;
      lim = longint'(horizon) << mbe_pkg::FRAC_BITS;
      for (longint n = 0; n < iter_limit; n++) begin
        if (sq_mag(zr) + sq_mag(zi) > lim) return 16'(n);
        re = (zr * zr - zi * zi) >>> mbe_pkg::FRAC_BITS;
        im = (zr * zi) >>> (mbe_pkg::FRAC_BITS - 1);
        zr = clamp_q(re + cr);
        zi = clamp_q(im + ci);
      end
      return '0;
    endfunction

    function void note_point(logic [mbe_pkg::IDX_W-1:0] c, logic [mbe_pkg::IDX_W-1:0] r);
      point_result_t e;
      longint        cr;
      longint        ci;
      cr      = clamp_q(x_min + longint'(c) * x_step);
      ci      = clamp_q(y_min + longint'(r) * y_step);
      e.col   = c;
      e.row   = r;
      e.count = escape_count_of(cr, ci);
      due_points.push_back(e);
    endfunction

    function void check_point(logic [mbe_pkg::IDX_W-1:0] c, logic [mbe_pkg::IDX_W-1:0] r,
                              logic [mbe_pkg::ITER_W-1:0] n);
      point_result_t e;
      if (due_points.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing due: col=%0d row=%0d count=%0d",
                 $time, c, r, n);
        return;
      end
      e = due_points.pop_front();
      if (e.col !== c || e.row !== r || e.count !== n) begin
        mismatches++;
        $display("%0t: expected col=%0d row=%0d count=%0d, actual col=%0d row=%0d count=%0d",
                 $time, e.col, e.row, e.count, c, r, n);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [mbe_pkg::IDX_W-1:0]     in_col;
  logic [mbe_pkg::IDX_W-1:0]     in_row;
  logic                          out_valid;
  logic [mbe_pkg::IDX_W-1:0]     out_col;
  logic [mbe_pkg::IDX_W-1:0]     out_row;
  logic [mbe_pkg::ITER_W-1:0]    out_escape_count;
  logic                          cfg_we;
  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mbe_pkg::CFG_DW-1:0]    cfg_data;

  escape_tracker tracker = new();
  int unsigned   points_sent;

  mandelbrot_escape_time i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_col           (in_col),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_col          (out_col),
    .out_row          (out_row),
    .out_escape_count (out_escape_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_point(out_col, out_row, out_escape_count);
      if (start && !busy) tracker.note_point(in_col, in_row);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL mandelbrot_escape_time");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [mbe_pkg::IDX_W-1:0] pick_index();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic put_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(input logic [31:0] xm, input logic [31:0] ym,
                           input logic [31:0] xs, input logic [31:0] ys,
                           input logic [31:0] iters, input logic [31:0] hz,
                           input bit spare);
    put_reg(mbe_pkg::REG_X_MIN, xm);
    put_reg(mbe_pkg::REG_Y_MIN, ym);
    put_reg(mbe_pkg::REG_X_STEP, xs);
    put_reg(mbe_pkg::REG_Y_STEP, ys);
    put_reg(mbe_pkg::REG_MAX_ITER, iters);
    put_reg(mbe_pkg::REG_HORIZON, hz);
    // unmapped index: must be ignored
    if (spare) put_reg(mbe_pkg::REG_HORIZON + 3'($urandom_range(1, 2)), $urandom());
    cfg_we <= 1'b0;
  endtask

  task automatic drive_point(input logic [mbe_pkg::IDX_W-1:0] c,
                             input logic [mbe_pkg::IDX_W-1:0] r, input bit quiet);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_col <= c;
    in_row <= r;
    do @(posedge clk); while (busy !== 1'b0);
    points_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.due_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_view();
    logic [31:0] v[6];
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 9) begin
      // window over the interesting region, coarse or zoomed
      v[0] = $urandom_range(0, 805306368) - 32'd671088640;
      v[1] = $urandom_range(0, 536870912) - 32'd402653184;
      v[2] = (sel < 7) ? $urandom_range(0, 1048576) : $urandom_range(0, 4096);
      v[3] = (sel < 7) ? $urandom_range(0, 1048576) : $urandom_range(0, 4096);
    end else begin
      v[0] = $urandom();
      v[1] = $urandom();
      v[2] = $urandom();
      v[3] = $urandom();
    end
    sel = $urandom_range(0, 19);
    if (sel == 0) v[4] = $urandom_range(0, 2);
    else if (sel < 15) v[4] = $urandom_range(1, 40);
    else v[4] = $urandom_range(41, 160);
    v[4] = v[4] | ($urandom() & 32'hFFFF_0000);
    sel = $urandom_range(0, 9);
    if (sel < 7) v[5] = 32'h4000_0000;
    else if (sel == 7) v[5] = $urandom_range(0, 32'h1000_0000);
    else v[5] = $urandom();
    configure(v[0], v[1], v[2], v[3], v[4], v[5], $urandom_range(0, 4) == 0);
  endtask

  initial begin
    int unsigned batch;
    bit          quiet;
    points_sent = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_col    <= '0;
    in_row    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // default view: corners, centre and points inside the set
    drive_point(10'd0, 10'd0, 1'b0);
    drive_point(10'd1023, 10'd1023, 1'b0);
    drive_point(10'd0, 10'd1023, 1'b0);
    drive_point(10'd1023, 10'd0, 1'b0);
    drive_point(10'd512, 10'd512, 1'b0);
    drive_point(10'd819, 10'd512, 1'b0);
    drain();

    // extreme origin and step: coordinates saturate, zero horizon
    configure(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'd4, 32'd0, 1'b0);
    drive_point(10'd0, 10'd0, 1'b0);
    drive_point(10'd1, 10'd1, 1'b0);
    drive_point(10'd1023, 10'd1023, 1'b0);
    drain();

    // zero iteration limit: no test made
    configure(32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'h7FFF_FFFF, 1'b1);
    drive_point(10'd0, 10'd0, 1'b0);
    drive_point(10'd1023, 10'd1023, 1'b1);
    drain();

    // longest limit: one point never escapes, others escape late or at once
    configure(32'd0, 32'd0, 32'h0010_0000, 32'h0010_0000, 32'h0000_FFFF,
              32'h4000_0000, 1'b0);
    drive_point(10'd0, 10'd0, 1'b0);
    drive_point(10'd80, 10'd0, 1'b0);
    drive_point(10'd1023, 10'd1023, 1'b0);
    drain();

    // escape at the first test
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd1, 32'h4000_0000, 1'b0);
    drive_point(10'd1023, 10'd1023, 1'b0);
    drain();

    // widest horizon: the update saturates both ways
    configure(32'd0, 32'hD000_0000, 32'h0020_0000, 32'h0020_0000, 32'd8,
              32'h7FFF_FFFF, 1'b0);
    drive_point(10'd358, 10'd384, 1'b0);
    drive_point(10'd243, 10'd627, 1'b1);
    drive_point(10'd243, 10'd141, 1'b0);
    drive_point(10'd0, 10'd0, 1'b0);
    drain();

    while (points_sent < POINT_TARGET) begin
      random_view();
      batch = $urandom_range(30, 110);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (batch) drive_point(pick_index(), pick_index(), quiet);
      drain();
    end

    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_points.size() == 0) begin
      $display("PASS mandelbrot_escape_time");
    end else begin
      $display("FAIL mandelbrot_escape_time");
    end
    $finish;
  end

endmodule
`default_nettype wire
